[src/snbb_pkg.sv]
// Package for the struck noise-burst exciter: sequencer states, register
// indexes and the control bundle of the shared multiply-accumulate unit.
// No dependencies.
package snbb_pkg;

    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int COEF_WIDTH = 24;
    localparam int BURST_WIDTH = 12;
    localparam int MAC_A_WIDTH = 33;
    localparam int MAC_B_WIDTH = 25;
    localparam int ACC_WIDTH = 64;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_B0 = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_B1 = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_B2 = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_A1 = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_A2 = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPM = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SEED = 3'd6;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_STRIKE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_NAMP,
        S_LO,
        S_HI,
        S_X,
        S_B0,
        S_B1,
        S_B2,
        S_A1,
        S_A2,
        S_OUT
    } t_state;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic en;     // perform an operation this cycle
        logic clr;    // start a fresh sum instead of accumulating
        logic sh24;   // weight the product by two to the 24th
    } t_mac_ctl;

endpackage

[src/snbb_if.sv]
// Valid/ready channel interfaces for the exciter's item and result streams.
// Depends on nothing; the sample widths follow the sample width parameter.
interface snbb_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [7:0]              hardness;
    logic [15:0]             amplitude;
    logic [SAMPLE_WIDTH-1:0] in_sample;

    modport source (output valid, func, hardness, amplitude, in_sample, input ready);
    modport sink (input valid, func, hardness, amplitude, in_sample, output ready);
endinterface

interface snbb_out_if #(parameter int SAMPLE_WIDTH = 16);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] out_sample;
    logic                    burst_active;

    modport source (output valid, out_sample, burst_active, input ready);
    modport sink (input valid, out_sample, burst_active, output ready);
endinterface

[src/snbb_mac.sv]
// Signed multiply-accumulate unit shared by the noise and filter products.
// Depends on snbb_pkg for widths and the control bundle.
module snbb_mac (
    input  logic                                     i_clk,
    input  snbb_pkg::t_mac_ctl                       i_ctl,
    input  logic signed [snbb_pkg::MAC_A_WIDTH-1:0]  i_a,
    input  logic signed [snbb_pkg::MAC_B_WIDTH-1:0]  i_b,
    output logic signed [snbb_pkg::ACC_WIDTH-1:0]    o_acc
);
    localparam int PW = snbb_pkg::MAC_A_WIDTH + snbb_pkg::MAC_B_WIDTH;

    logic signed [PW-1:0]                  w_prod;
    logic signed [snbb_pkg::ACC_WIDTH-1:0] w_term;
    logic signed [snbb_pkg::ACC_WIDTH-1:0] w_base;
    logic signed [snbb_pkg::ACC_WIDTH-1:0] r_acc;

    assign w_prod = i_a * i_b;
    assign w_term = i_ctl.sh24 ? (snbb_pkg::ACC_WIDTH'(w_prod) <<< 24)
                               : snbb_pkg::ACC_WIDTH'(w_prod);
    assign w_base = i_ctl.clr ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= w_base + w_term;
        end
    end

    assign o_acc = r_acc;
endmodule

[src/struck_noise_burst_biquad.sv]
// Top level of the struck noise-burst exciter with biquad low-pass.
// Depends on snbb_pkg, the channel interfaces in snbb_if and snbb_mac.
//
// Usage: items arrive on i_in (valid/ready). func selects a strike, which
// loads amplitude, sizes the burst from hardness and starts it, or a sample,
// which adds the next filtered noise-burst sample to in_sample. Every item
// yields one result item on o_out: the mixed sample and a flag that is high
// while burst samples remain. Coefficients, samples per millisecond and the
// noise seed are written through the plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data); the user must do so only while the block is idle, which the
// block itself does not enforce. A seed write reloads the generator at once.
//
// Timing: a strike, or a sample after the burst has ended, is answered in
// the next cycle. A sample inside the burst runs through a small sequencer:
// the restoring divider that forms the envelope index (skipped for a one-sample
// burst), three passes of the shared multiplier for noise times amplitude
// times envelope, one saturation step, five filter taps on the same
// multiplier and one output step. The sequencer then returns to idle and
// takes no new item before it is back there.
//
// Reset loads the generator with one, clears burst and filter state and
// restores the register defaults. The envelope table is constant logic and
// needs no fill. When the receiver stalls, the result stays in the output
// register and no new item is taken until it has been delivered.
module struck_noise_burst_biquad #(
    parameter int ENV_TABLE_DEPTH = 256,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    snbb_in_if.sink                               i_in,
    snbb_out_if.source                            o_out,
    input  logic                                  i_cfg_we,
    input  logic [snbb_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [snbb_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);
    localparam int IDXW = $clog2(ENV_TABLE_DEPTH);
    localparam int BW = snbb_pkg::BURST_WIDTH;
    localparam int CW = snbb_pkg::COEF_WIDTH;
    localparam int AW = snbb_pkg::ACC_WIDTH;
    localparam int DVW = BW + IDXW + 2;
    localparam logic [BW-1:0] BURST_MAX = {BW{1'b1}};
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(ENV_TABLE_DEPTH - 1);
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    // Shift from the Q2.22 filter output to the sample format.
    localparam int YSH = 23 - SAMPLE_WIDTH;
    localparam int YSH_R = (YSH > 0) ? YSH : 0;
    localparam longint YRND = (64'sd1 <<< YSH_R) >>> 1;
    localparam int YSH_L = (YSH < 0) ? 1 : 0;
    localparam int MW = 27;
    localparam longint SMAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SMIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

    // One entry of the descending half-Hann envelope: cos^2 by a Q30 Taylor
    // series, clamped, squared and rounded to Q1.15.
    function automatic longint env_entry(input longint k);
        longint x;
        longint x2;
        longint c;
        x = HALF_PI_Q30 * k / (ENV_TABLE_DEPTH - 1);
        x2 = longint'(unsigned'(x * x) >> 30);
        c = Q30_ONE;
        c = Q30_ONE - (x2 * c) / (Q30_ONE * 132);
        c = Q30_ONE - (x2 * c) / (Q30_ONE * 90);
        c = Q30_ONE - (x2 * c) / (Q30_ONE * 56);
        c = Q30_ONE - (x2 * c) / (Q30_ONE * 30);
        c = Q30_ONE - (x2 * c) / (Q30_ONE * 12);
        c = Q30_ONE - (x2 * c) / (Q30_ONE * 2);
        if (c < 0) c = 0;
        if (c > Q30_ONE) c = Q30_ONE;
        return (c * c + (64'sd1 <<< 44)) >>> 45;
    endfunction

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic signed [CW-1:0] sat24(input logic signed [AW-1:0] v);
        if (v > AW'(64'sd8388607)) return 24'sh7FFFFF;
        if (v < AW'(-64'sd8388608)) return 24'sh800000;
        return v[CW-1:0];
    endfunction

    logic [15:0] w_env [ENV_TABLE_DEPTH];
    for (genvar k = 0; k < ENV_TABLE_DEPTH; k++) begin : g_env
        assign w_env[k] = 16'(env_entry(longint'(k)));
    end

    // Configuration registers. The seed only ever lands in the generator.
    logic signed [CW-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [7:0]           r_spm;

    // Voice state.
    logic [31:0]          r_noise;
    logic [BW-1:0]        r_total, r_pos;
    logic [15:0]          r_amp;
    logic signed [CW-1:0] r_in1, r_in2, r_out1, r_out2;

    // Sequencer working registers.
    snbb_pkg::t_state     r_state, n_state;
    logic [DVW-1:0]       r_rem, r_dsh;
    logic [IDXW-1:0]      r_q, r_cnt;
    logic [15:0]          r_env;
    logic signed [23:0]   r_p1hi;
    logic signed [CW-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_mix;

    // Output register.
    logic                    r_ov;
    logic [SAMPLE_WIDTH-1:0] r_osample;
    logic                    r_oactive;

    snbb_pkg::t_mac_ctl                      w_ctl;
    logic signed [snbb_pkg::MAC_A_WIDTH-1:0] w_a;
    logic signed [snbb_pkg::MAC_B_WIDTH-1:0] w_b;
    logic signed [AW-1:0]                    w_acc;

    logic w_accept, w_strike, w_burst, w_div_ge;
    logic [16:0] w_len_prod;
    logic [12:0] w_len_raw;
    logic [BW-1:0] w_len;
    logic signed [CW-1:0] w_xsat, w_y;
    logic signed [MW-1:0] w_ys, w_sum;
    logic [SAMPLE_WIDTH-1:0] w_res;

    assign i_in.ready = (r_state == snbb_pkg::S_IDLE) && (!r_ov || o_out.ready);
    assign w_accept = i_in.valid && i_in.ready;
    assign w_strike = w_accept && (i_in.func == snbb_pkg::FUNC_STRIKE);
    assign w_burst = w_accept && (i_in.func == snbb_pkg::FUNC_SAMPLE) && (r_pos < r_total);

    // Burst length: floor(spm * (320 - hardness) / 16), clamped to 1..4095.
    assign w_len_prod = 17'(r_spm) * (17'd320 - 17'(i_in.hardness));
    assign w_len_raw = w_len_prod[16:4];
    assign w_len = (w_len_raw == '0) ? BW'(1)
                 : (w_len_raw > 13'(BURST_MAX)) ? BURST_MAX : w_len_raw[BW-1:0];

    assign w_div_ge = r_rem >= r_dsh;

    // Excitation: round the Q0.31 x Q1.15 x Q1.15 product to Q2.22.
    assign w_xsat = sat24((w_acc + (64'sd1 <<< 38)) >>> 39);
    // Filter output in Q2.22, then scaled to the sample format.
    assign w_y = sat24((w_acc + (64'sd1 <<< 21)) >>> 22);
    always_comb begin
        if (YSH_L != 0) begin
            w_ys = MW'(w_y) <<< 1;
        end else begin
            w_ys = (MW'(w_y) + MW'(YRND)) >>> YSH_R;
        end
        w_sum = MW'(r_mix) + w_ys;
        if (w_sum > MW'(SMAX)) begin
            w_res = SAMPLE_WIDTH'(SMAX);
        end else if (w_sum < MW'(SMIN)) begin
            w_res = SAMPLE_WIDTH'(SMIN);
        end else begin
            w_res = w_sum[SAMPLE_WIDTH-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            snbb_pkg::S_IDLE: begin
                if (w_burst) begin
                    n_state = (r_total > BW'(1)) ? snbb_pkg::S_DIV : snbb_pkg::S_NAMP;
                end
            end
            snbb_pkg::S_DIV: begin
                if (r_cnt == '0) n_state = snbb_pkg::S_NAMP;
            end
            snbb_pkg::S_NAMP: n_state = snbb_pkg::S_LO;
            snbb_pkg::S_LO:   n_state = snbb_pkg::S_HI;
            snbb_pkg::S_HI:   n_state = snbb_pkg::S_X;
            snbb_pkg::S_X:    n_state = snbb_pkg::S_B0;
            snbb_pkg::S_B0:   n_state = snbb_pkg::S_B1;
            snbb_pkg::S_B1:   n_state = snbb_pkg::S_B2;
            snbb_pkg::S_B2:   n_state = snbb_pkg::S_A1;
            snbb_pkg::S_A1:   n_state = snbb_pkg::S_A2;
            snbb_pkg::S_A2:   n_state = snbb_pkg::S_OUT;
            snbb_pkg::S_OUT:  n_state = snbb_pkg::S_IDLE;
            default:          n_state = snbb_pkg::S_IDLE;
        endcase
    end

    // Multiplier operand selection.
    always_comb begin
        w_ctl = '0;
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            snbb_pkg::S_NAMP: begin
                w_ctl = '{en: 1'b1, clr: 1'b1, sh24: 1'b0};
                w_a = snbb_pkg::MAC_A_WIDTH'($signed(r_noise));
                w_b = $signed({9'd0, r_amp});
            end
            snbb_pkg::S_LO: begin
                w_ctl = '{en: 1'b1, clr: 1'b1, sh24: 1'b0};
                w_a = $signed({9'd0, w_acc[23:0]});
                w_b = $signed({9'd0, r_env});
            end
            snbb_pkg::S_HI: begin
                w_ctl = '{en: 1'b1, clr: 1'b0, sh24: 1'b1};
                w_a = snbb_pkg::MAC_A_WIDTH'(r_p1hi);
                w_b = $signed({9'd0, r_env});
            end
            snbb_pkg::S_B0: begin
                w_ctl = '{en: 1'b1, clr: 1'b1, sh24: 1'b0};
                w_a = snbb_pkg::MAC_A_WIDTH'(r_x);
                w_b = snbb_pkg::MAC_B_WIDTH'(r_b0);
            end
            snbb_pkg::S_B1: begin
                w_ctl = '{en: 1'b1, clr: 1'b0, sh24: 1'b0};
                w_a = snbb_pkg::MAC_A_WIDTH'(r_in1);
                w_b = snbb_pkg::MAC_B_WIDTH'(r_b1);
            end
            snbb_pkg::S_B2: begin
                w_ctl = '{en: 1'b1, clr: 1'b0, sh24: 1'b0};
                w_a = snbb_pkg::MAC_A_WIDTH'(r_in2);
                w_b = snbb_pkg::MAC_B_WIDTH'(r_b2);
            end
            snbb_pkg::S_A1: begin
                w_ctl = '{en: 1'b1, clr: 1'b0, sh24: 1'b0};
                w_a = snbb_pkg::MAC_A_WIDTH'(r_out1);
                w_b = -snbb_pkg::MAC_B_WIDTH'(r_a1);
            end
            snbb_pkg::S_A2: begin
                w_ctl = '{en: 1'b1, clr: 1'b0, sh24: 1'b0};
                w_a = snbb_pkg::MAC_A_WIDTH'(r_out2);
                w_b = -snbb_pkg::MAC_B_WIDTH'(r_a2);
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    snbb_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_acc (w_acc)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= snbb_pkg::S_IDLE;
            r_ov <= 1'b0;
            r_b0 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
            r_spm <= 8'd48;
            r_noise <= 32'd1;
            r_total <= '0;
            r_pos <= '0;
            r_amp <= '0;
            r_in1 <= '0;
            r_in2 <= '0;
            r_out1 <= '0;
            r_out2 <= '0;
        end else begin
            r_state <= n_state;

            if (w_accept && !w_burst) begin
                r_ov <= 1'b1;
            end else if (r_state == snbb_pkg::S_OUT) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    snbb_pkg::CFG_B0:   r_b0 <= i_cfg_data[CW-1:0];
                    snbb_pkg::CFG_B1:   r_b1 <= i_cfg_data[CW-1:0];
                    snbb_pkg::CFG_B2:   r_b2 <= i_cfg_data[CW-1:0];
                    snbb_pkg::CFG_A1:   r_a1 <= i_cfg_data[CW-1:0];
                    snbb_pkg::CFG_A2:   r_a2 <= i_cfg_data[CW-1:0];
                    snbb_pkg::CFG_SPM:  r_spm <= i_cfg_data[7:0];
                    // The seed goes straight into the generator below.
                    snbb_pkg::CFG_SEED: ;
                    default: ;
                endcase
            end

            if (i_cfg_we && (i_cfg_idx == snbb_pkg::CFG_SEED)) begin
                r_noise <= i_cfg_data;
            end else if (w_burst) begin
                r_noise <= xorshift(r_noise);
            end

            if (w_strike) begin
                r_total <= w_len;
                r_pos <= '0;
                r_amp <= i_in.amplitude;
                r_in1 <= '0;
                r_in2 <= '0;
                r_out1 <= '0;
                r_out2 <= '0;
            end else if (r_state == snbb_pkg::S_OUT) begin
                r_pos <= r_pos + BW'(1);
                r_in2 <= r_in1;
                r_in1 <= r_x;
                r_out2 <= r_out1;
                r_out1 <= w_y;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_burst) begin
            r_mix <= i_in.in_sample;
            r_rem <= DVW'(2 * r_pos) * DVW'(ENV_TABLE_DEPTH - 1) + DVW'(r_total - BW'(1));
            r_dsh <= DVW'(2 * (r_total - BW'(1))) << (IDXW - 1);
            r_cnt <= IDXW'(IDXW - 1);
            r_q <= IDX_LAST;
        end else if (r_state == snbb_pkg::S_DIV) begin
            if (w_div_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q <= {r_q[IDXW-2:0], w_div_ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - IDXW'(1);
        end
        if (r_state == snbb_pkg::S_NAMP) begin
            r_env <= w_env[r_q];
        end
        if (r_state == snbb_pkg::S_LO) begin
            r_p1hi <= w_acc[47:24];
        end
        if (r_state == snbb_pkg::S_X) begin
            r_x <= w_xsat;
        end
        if (w_accept && !w_burst) begin
            r_osample <= i_in.in_sample;
            r_oactive <= w_strike ? 1'b1 : 1'b0;
        end else if (r_state == snbb_pkg::S_OUT) begin
            r_osample <= w_res;
            r_oactive <= (r_pos + BW'(1)) < r_total;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.out_sample = r_osample;
    assign o_out.burst_active = r_oactive;

    // The sequencer never takes an item while busy.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != snbb_pkg::S_IDLE) |-> !i_in.ready)
        else $error("item accepted while the sequencer is busy");

    // A burst result only lands in an empty output register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == snbb_pkg::S_OUT) |-> !r_ov)
        else $error("burst result would overwrite a pending result");

    // A strike is answered next cycle with the burst flagged active.
    a_strike_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_strike |=> (r_ov && r_oactive))
        else $error("strike result missing or not active");

    // The burst position never runs past the burst length.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_total)
        else $error("burst position beyond burst length");
endmodule
